>>> hw/rtl/cluster_pair_list_prune_core_macros.svh
// assertion macros for the cluster pair list prune checker
`ifndef CLUSTER_PAIR_LIST_PRUNE_CORE_MACROS_SVH
`define CLUSTER_PAIR_LIST_PRUNE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CLPP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CLPP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/clpp_pkg.sv
// shared types, constants and arithmetic helpers for the cluster pair list prune core
package clpp_pkg;

  localparam int COORD_W = 32;
  localparam int IDX_W   = 24;
  localparam int SW_W    = 16;
  localparam int CUT_W   = 62;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 2;

  // input tdata layout
  localparam int IN_CI_LSB   = 0;
  localparam int IN_SW_LSB   = IN_CI_LSB + IDX_W;
  localparam int IN_SX_LSB   = IN_SW_LSB + SW_W;
  localparam int IN_SY_LSB   = IN_SX_LSB + COORD_W;
  localparam int IN_SZ_LSB   = IN_SY_LSB + COORD_W;
  localparam int IN_AX_LSB   = IN_SZ_LSB + COORD_W;
  localparam int IN_AY_LSB   = IN_AX_LSB + COORD_W;
  localparam int IN_AZ_LSB   = IN_AY_LSB + COORD_W;
  localparam int IN_SLOT_LSB = IN_AZ_LSB + COORD_W;
  localparam int IN_CJ_LSB   = IN_SLOT_LSB + SLOT_W;
  localparam int IN_USED_W   = IN_CJ_LSB + IDX_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_KEPT_BIT = 0;
  localparam int OUT_CI_LSB   = 1;
  localparam int OUT_SW_LSB   = OUT_CI_LSB + IDX_W;
  localparam int OUT_CJ_LSB   = OUT_SW_LSB + SW_W;
  localparam int OUT_POS_LSB  = OUT_CJ_LSB + IDX_W;
  localparam int OUT_RS_LSB   = OUT_POS_LSB + IDX_W;
  localparam int OUT_RE_LSB   = OUT_RS_LSB + IDX_W;
  localparam int OUT_USED_W   = OUT_RE_LSB + IDX_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 2'd0,
    OP_IATOM = 2'd1,
    OP_JATOM = 2'd2,
    OP_END   = 2'd3
  } opcode_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_ENTRY   = 1'b1
  } kind_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0] mag_t;
  typedef logic [SQ_W-1:0] sq_t;

  typedef struct packed {
    sq_t x;
    sq_t y;
    sq_t z;
  } sq3_t;

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

  // |a - b| always fits the coordinate width as unsigned
  function automatic mag_t abs_diff(coord_t a, coord_t b);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

>>> hw/rtl/clpp_rsq_check.sv
// squared distance sum of one i atom against one j atom, compared with the cutoff
module clpp_rsq_check (
  input  clpp_pkg::sq3_t                 sq,
  input  logic [clpp_pkg::CUT_W-1:0]     cutoff,
  output logic                           hit
);

  localparam int SW = clpp_pkg::SUM_W;

  logic [SW-1:0] sum;

  // saturation at the top of the range never drops below cutoff, so the plain sum works
  assign sum = SW'(sq.x) + SW'(sq.y) + SW'(sq.z);
  assign hit = sum < SW'(cutoff);

endmodule

>>> hw/rtl/cluster_pair_list_prune_core.sv
// cluster pair list prune core: top level with three-stage pipeline and result register
// results reach the result register through stages a, b and c and are held there until taken
// throughput: one input beat per cycle unless the output stalls, three squares per lane
// each stage moves on when the next one is empty or moving, so bubbles close up
// reset: synchronous rst clears the pipe, counters, coordinates and cutoff to zero at once
module cluster_pair_list_prune_core #(
  parameter int I_CLUSTER_SIZE = 4,
  parameter int INDEX_BITS     = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // ci_index, shift_word, shift_x, shift_y, shift_z, atom_x, atom_y, atom_z, atom_slot, cj_index
  input  logic [clpp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // opcode
  input  logic [clpp_pkg::OP_W-1:0]         s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // kept, out_ci_index, out_shift_word, out_cj_index, out_position, range_start, range_end
  output logic [clpp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // kind
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clpp_pkg::CUT_W-1:0]        cfg_data
);

  localparam int CW = clpp_pkg::COORD_W;
  localparam int IW = clpp_pkg::IDX_W;
  localparam int WW = clpp_pkg::SW_W;

  logic [clpp_pkg::CUT_W-1:0] cutoff_sq;

  // stage a
  logic                         a_v;
  clpp_pkg::opcode_t            a_op;
  logic [IW-1:0]                a_ci;
  logic [WW-1:0]                a_sw;
  clpp_pkg::coord_t             a_shv [3];
  clpp_pkg::coord_t             a_atom [3];
  logic [clpp_pkg::SLOT_W-1:0]  a_slot;
  logic [IW-1:0]                a_cj;
  logic                         a_last;
  clpp_pkg::coord_t             a_shifted [3];
  clpp_pkg::mag_t               a_mag [I_CLUSTER_SIZE][3];

  // stage b
  logic                         b_v;
  clpp_pkg::opcode_t            b_op;
  logic [IW-1:0]                b_ci;
  logic [WW-1:0]                b_sw;
  logic [IW-1:0]                b_cj;
  logic                         b_last;
  clpp_pkg::mag_t               b_mag [I_CLUSTER_SIZE][3];

  // stage c
  logic                         c_v;
  clpp_pkg::opcode_t            c_op;
  logic [IW-1:0]                c_ci;
  logic [WW-1:0]                c_sw;
  logic [IW-1:0]                c_cj;
  logic                         c_last;
  clpp_pkg::sq3_t               c_sq [I_CLUSTER_SIZE];
  logic [I_CLUSTER_SIZE-1:0]    c_hit_vec;
  logic                         c_hit_all;
  logic                         c_res;

  // result register
  logic                         o_v;
  clpp_pkg::kind_t              o_kind;
  logic                         o_kept;
  logic [IW-1:0]                o_ci;
  logic [WW-1:0]                o_sw;
  logic [IW-1:0]                o_cj;
  logic [IW-1:0]                o_pos;
  logic [IW-1:0]                o_rs;
  logic [IW-1:0]                o_re;

  // cluster state
  clpp_pkg::coord_t             icrd [I_CLUSTER_SIZE][3];
  clpp_pkg::coord_t             shift [3];
  logic [INDEX_BITS-1:0]        cur_ci;
  logic [WW-1:0]                cur_sw;
  logic                         any_hit;
  logic [INDEX_BITS-1:0]        kept_j;
  logic [INDEX_BITS-1:0]        kept_i;
  logic [INDEX_BITS-1:0]        entry_start;

  logic s_acc;
  logic a_go;
  logic b_go;
  logic c_go;

  assign cfg_ready = 1'b1;

  // flow control
  assign c_res = c_v && ((c_op == clpp_pkg::OP_JATOM && c_last) ||
                         (c_op == clpp_pkg::OP_END && kept_j != entry_start));
  assign c_go  = c_v && (!c_res || !o_v || m_axis_tready);
  assign b_go  = b_v && (!c_v || c_go);
  assign a_go  = a_v && (!b_v || b_go);
  assign s_axis_tready = !a_v || a_go;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // stage a logic
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      a_shifted[d] = clpp_pkg::sat_add(a_atom[d], shift[d]);
    end
    for (int k = 0; k < I_CLUSTER_SIZE; k++) begin
      for (int d = 0; d < 3; d++) begin
        a_mag[k][d] = clpp_pkg::abs_diff(icrd[k][d], a_atom[d]);
      end
    end
  end

  // stage c hit checks, one lane per i atom
  for (genvar k = 0; k < I_CLUSTER_SIZE; k++) begin : g_lane
    clpp_rsq_check u_rsq (
      .sq     (c_sq[k]),
      .cutoff (cutoff_sq),
      .hit    (c_hit_vec[k])
    );
  end

  assign c_hit_all = any_hit || (|c_hit_vec);

  // control and cluster state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v         <= 1'b0;
      b_v         <= 1'b0;
      c_v         <= 1'b0;
      o_v         <= 1'b0;
      cutoff_sq   <= '0;
      cur_ci      <= '0;
      cur_sw      <= '0;
      any_hit     <= 1'b0;
      kept_j      <= '0;
      kept_i      <= '0;
      entry_start <= '0;
      for (int d = 0; d < 3; d++) begin
        shift[d] <= '0;
      end
      for (int k = 0; k < I_CLUSTER_SIZE; k++) begin
        for (int d = 0; d < 3; d++) begin
          icrd[k][d] <= '0;
        end
      end
    end else begin
      if (cfg_valid) begin
        cutoff_sq <= cfg_data;
      end
      a_v <= s_acc ? 1'b1 : (a_go ? 1'b0 : a_v);
      b_v <= a_go ? 1'b1 : (b_go ? 1'b0 : b_v);
      c_v <= b_go ? 1'b1 : (c_go ? 1'b0 : c_v);
      o_v <= (c_go && c_res) ? 1'b1 : (m_axis_tready ? 1'b0 : o_v);

      if (a_go && a_op == clpp_pkg::OP_BEGIN) begin
        shift <= a_shv;
      end
      if (a_go && a_op == clpp_pkg::OP_IATOM) begin
        for (int k = 0; k < I_CLUSTER_SIZE; k++) begin
          if (int'(a_slot) == k) begin
            icrd[k] <= a_shifted;
          end
        end
      end

      if (c_go) begin
        case (c_op)
          clpp_pkg::OP_BEGIN: begin
            cur_ci      <= INDEX_BITS'(c_ci);
            cur_sw      <= c_sw;
            entry_start <= kept_j;
            any_hit     <= 1'b0;
          end
          clpp_pkg::OP_JATOM: begin
            if (c_last) begin
              if (c_hit_all) begin
                kept_j <= kept_j + 1'b1;
              end
              any_hit <= 1'b0;
            end else begin
              any_hit <= c_hit_all;
            end
          end
          clpp_pkg::OP_END: begin
            any_hit <= 1'b0;
            if (kept_j != entry_start) begin
              kept_i      <= kept_i + 1'b1;
              entry_start <= kept_j;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      a_op      <= clpp_pkg::opcode_t'(s_axis_tuser);
      a_ci      <= s_axis_tdata[clpp_pkg::IN_CI_LSB +: IW];
      a_sw      <= s_axis_tdata[clpp_pkg::IN_SW_LSB +: WW];
      a_shv[0]  <= s_axis_tdata[clpp_pkg::IN_SX_LSB +: CW];
      a_shv[1]  <= s_axis_tdata[clpp_pkg::IN_SY_LSB +: CW];
      a_shv[2]  <= s_axis_tdata[clpp_pkg::IN_SZ_LSB +: CW];
      a_atom[0] <= s_axis_tdata[clpp_pkg::IN_AX_LSB +: CW];
      a_atom[1] <= s_axis_tdata[clpp_pkg::IN_AY_LSB +: CW];
      a_atom[2] <= s_axis_tdata[clpp_pkg::IN_AZ_LSB +: CW];
      a_slot    <= s_axis_tdata[clpp_pkg::IN_SLOT_LSB +: clpp_pkg::SLOT_W];
      a_cj      <= s_axis_tdata[clpp_pkg::IN_CJ_LSB +: IW];
      a_last    <= s_axis_tlast;
    end
    if (a_go) begin
      b_op   <= a_op;
      b_ci   <= a_ci;
      b_sw   <= a_sw;
      b_cj   <= a_cj;
      b_last <= a_last;
      b_mag  <= a_mag;
    end
    if (b_go) begin
      c_op   <= b_op;
      c_ci   <= b_ci;
      c_sw   <= b_sw;
      c_cj   <= b_cj;
      c_last <= b_last;
      for (int k = 0; k < I_CLUSTER_SIZE; k++) begin
        c_sq[k].x <= b_mag[k][0] * b_mag[k][0];
        c_sq[k].y <= b_mag[k][1] * b_mag[k][1];
        c_sq[k].z <= b_mag[k][2] * b_mag[k][2];
      end
    end
    if (c_go && c_res) begin
      if (c_op == clpp_pkg::OP_JATOM) begin
        o_kind <= clpp_pkg::KIND_VERDICT;
        o_kept <= c_hit_all;
        o_ci   <= '0;
        o_sw   <= '0;
        o_cj   <= c_cj;
        o_pos  <= IW'(kept_j);
        o_rs   <= '0;
        o_re   <= '0;
      end else begin
        o_kind <= clpp_pkg::KIND_ENTRY;
        o_kept <= 1'b0;
        o_ci   <= IW'(cur_ci);
        o_sw   <= cur_sw;
        o_cj   <= '0;
        o_pos  <= IW'(kept_i);
        o_rs   <= IW'(entry_start);
        o_re   <= IW'(kept_j);
      end
    end
  end

  // output packing
  assign m_axis_tvalid = o_v;
  assign m_axis_tuser  = o_kind;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[clpp_pkg::OUT_KEPT_BIT]       = o_kept;
    m_axis_tdata[clpp_pkg::OUT_CI_LSB +: IW]   = o_ci;
    m_axis_tdata[clpp_pkg::OUT_SW_LSB +: WW]   = o_sw;
    m_axis_tdata[clpp_pkg::OUT_CJ_LSB +: IW]   = o_cj;
    m_axis_tdata[clpp_pkg::OUT_POS_LSB +: IW]  = o_pos;
    m_axis_tdata[clpp_pkg::OUT_RS_LSB +: IW]   = o_rs;
    m_axis_tdata[clpp_pkg::OUT_RE_LSB +: IW]   = o_re;
  end

endmodule

>>> hw/rtl/clpp_port_checker.sv
// port checker for the cluster pair list prune core, with its bind
`include "cluster_pair_list_prune_core_macros.svh"

module clpp_port_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [clpp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic                              m_axis_tuser
);

  localparam int IW = clpp_pkg::IDX_W;
  localparam int PW = clpp_pkg::OUT_DATA_W - clpp_pkg::OUT_USED_W;

  logic                     f_kept;
  logic [IW-1:0]            f_ci;
  logic [clpp_pkg::SW_W-1:0] f_sw;
  logic [IW-1:0]            f_cj;
  logic [IW-1:0]            f_rs;
  logic [IW-1:0]            f_re;
  logic [PW-1:0]            f_pad;
  logic                     is_verdict;
  logic                     is_entry;
  logic                     stall;
  logic [clpp_pkg::OUT_DATA_W:0] beat;
  logic                     verdict_clean;
  logic                     entry_clean;

  assign f_kept = m_axis_tdata[clpp_pkg::OUT_KEPT_BIT];
  assign f_ci   = m_axis_tdata[clpp_pkg::OUT_CI_LSB +: IW];
  assign f_sw   = m_axis_tdata[clpp_pkg::OUT_SW_LSB +: clpp_pkg::SW_W];
  assign f_cj   = m_axis_tdata[clpp_pkg::OUT_CJ_LSB +: IW];
  assign f_rs   = m_axis_tdata[clpp_pkg::OUT_RS_LSB +: IW];
  assign f_re   = m_axis_tdata[clpp_pkg::OUT_RE_LSB +: IW];
  assign f_pad  = m_axis_tdata[clpp_pkg::OUT_USED_W +: PW];

  assign is_verdict = m_axis_tvalid && m_axis_tuser == clpp_pkg::KIND_VERDICT;
  assign is_entry   = m_axis_tvalid && m_axis_tuser == clpp_pkg::KIND_ENTRY;

  assign stall         = m_axis_tvalid && !m_axis_tready;
  assign beat          = {m_axis_tuser, m_axis_tdata};
  assign verdict_clean = f_ci == '0 && f_sw == '0 && f_rs == '0 && f_re == '0;
  assign entry_clean   = !f_kept && f_cj == '0;

  `CLPP_ASSERT_NXT(a_out_hold, stall, m_axis_tvalid && $stable(beat), "stalled beat changed")
  `CLPP_ASSERT_IMP(a_verdict_fields, is_verdict, verdict_clean, "verdict carries entry fields")
  `CLPP_ASSERT_IMP(a_entry_fields, is_entry, entry_clean, "entry carries verdict fields")
  `CLPP_ASSERT_IMP(a_pad_zero, m_axis_tvalid, f_pad == '0, "result padding not zero")

endmodule

bind cluster_pair_list_prune_core clpp_port_checker u_port_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for cluster_pair_list_prune_core with a result scoreboard
module tb;

  localparam int CLUSTER_ATOMS = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS = 395;
  localparam int IW = clpp_pkg::IDX_W;
  localparam int WW = clpp_pkg::SW_W;
  localparam int SLW = clpp_pkg::SLOT_W;
  localparam int CTW = clpp_pkg::CUT_W;
  localparam int CW = clpp_pkg::COORD_W;
  localparam longint unsigned RSQ_MAX = 64'h3fff_ffff_ffff_ffff;
  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;
  localparam clpp_pkg::coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam clpp_pkg::coord_t COORD_MIN = 32'sh8000_0000;

  typedef struct {
    clpp_pkg::opcode_t op;
    logic [IW-1:0] ci;
    logic [WW-1:0] sw;
    clpp_pkg::coord_t sx, sy, sz;
    clpp_pkg::coord_t ax, ay, az;
    logic [SLW-1:0] slot;
    logic [IW-1:0] cj;
    logic last;
  } pair_item_t;

  typedef struct packed {
    clpp_pkg::kind_t kind;
    logic kept;
    logic [IW-1:0] ci;
    logic [WW-1:0] sw;
    logic [IW-1:0] cj;
    logic [IW-1:0] pos;
    logic [IW-1:0] rs;
    logic [IW-1:0] re;
  } prune_result_t;

  class prune_scoreboard;
    longint unsigned cutoff;
    longint icoord[3*CLUSTER_ATOMS];
    longint shift[3];
    logic [IW-1:0] cur_ci, kept_j, kept_i, start;
    logic [WW-1:0] cur_sw;
    bit hit;
    prune_result_t expected_q[$];
    int mismatches, items, verdicts, kept_verdicts, entries;

    function new();
      foreach (icoord[k]) icoord[k] = 0;
      foreach (shift[k]) shift[k] = 0;
      cur_ci = '0;
      kept_j = '0;
      kept_i = '0;
      start = '0;
      cur_sw = '0;
      hit = 0;
      cutoff = 0;
      mismatches = 0;
      items = 0;
      verdicts = 0;
      kept_verdicts = 0;
      entries = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
    endfunction

    function longint unsigned dist_sq(longint a, longint b);
      longint d;
      longint unsigned m;
      d = a - b;
      m = (d < 0) ? longint'(-d) : d;
      return m * m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(pair_item_t it);
      prune_result_t r;
      longint jc[3];
      longint unsigned rsq, part;
      int k, c;
      items++;
      r = '0;
      jc[0] = longint'(it.ax);
      jc[1] = longint'(it.ay);
      jc[2] = longint'(it.az);
      case (it.op)
        clpp_pkg::OP_BEGIN: begin
          cur_ci = it.ci;
          cur_sw = it.sw;
          shift[0] = longint'(it.sx);
          shift[1] = longint'(it.sy);
          shift[2] = longint'(it.sz);
          start = kept_j;
          hit = 0;
        end
        clpp_pkg::OP_IATOM: begin
          for (c = 0; c < 3; c++)
            icoord[int'(it.slot)*3 + c] = clamp32(jc[c] + shift[c]);
        end
        clpp_pkg::OP_JATOM: begin
          for (k = 0; k < CLUSTER_ATOMS; k++) begin
            rsq = 0;
            for (c = 0; c < 3; c++) begin
              part = dist_sq(icoord[k*3 + c], jc[c]);
              rsq = (part > RSQ_MAX - rsq) ? RSQ_MAX : rsq + part;
            end
            if (rsq < cutoff) hit = 1;
          end
          if (it.last) begin
            r.kind = clpp_pkg::KIND_VERDICT;
            r.kept = hit;
            r.cj = it.cj;
            r.pos = kept_j;
            if (hit) kept_j++;
            hit = 0;
            expected_q = {expected_q, r};
            verdicts++;
            if (r.kept) kept_verdicts++;
          end
        end
        default: begin
          hit = 0;
          if (kept_j != start) begin
            r.kind = clpp_pkg::KIND_ENTRY;
            r.ci = cur_ci;
            r.sw = cur_sw;
            r.pos = kept_i;
            r.rs = start;
            r.re = kept_j;
            kept_i++;
            start = kept_j;
            expected_q = {expected_q, r};
            entries++;
          end
        end
      endcase
    endfunction

    function string fmt(prune_result_t r);
      return $sformatf("kind=%0d kept=%0d ci=%06h sw=%04h cj=%06h pos=%0d range=%0d..%0d",
                       r.kind, r.kept, r.ci, r.sw, r.cj, r.pos, r.rs, r.re);
    endfunction

    function void check_result(logic kind, logic [clpp_pkg::OUT_DATA_W-1:0] data);
      prune_result_t got, want;
      got.kind = clpp_pkg::kind_t'(kind);
      got.kept = data[clpp_pkg::OUT_KEPT_BIT];
      got.ci = data[clpp_pkg::OUT_CI_LSB +: IW];
      got.sw = data[clpp_pkg::OUT_SW_LSB +: WW];
      got.cj = data[clpp_pkg::OUT_CJ_LSB +: IW];
      got.pos = data[clpp_pkg::OUT_POS_LSB +: IW];
      got.rs = data[clpp_pkg::OUT_RS_LSB +: IW];
      got.re = data[clpp_pkg::OUT_RE_LSB +: IW];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with none pending: %s", fmt(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.kept !== want.kept || got.ci !== want.ci ||
          got.sw !== want.sw || got.cj !== want.cj || got.pos !== want.pos ||
          got.rs !== want.rs || got.re !== want.re) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result beat differs, expected %s", fmt(want));
          $display("                     actual   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [clpp_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [clpp_pkg::OP_W-1:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [clpp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CTW-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stuck_cycles = 0;
  prune_scoreboard sb;

  cluster_pair_list_prune_core #(
    .I_CLUSTER_SIZE(CLUSTER_ATOMS),
    .INDEX_BITS(IW)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic pair_item_t mk(clpp_pkg::opcode_t op, clpp_pkg::coord_t x,
                                    clpp_pkg::coord_t y, clpp_pkg::coord_t z, logic last);
    pair_item_t it;
    it.op = op;
    it.ci = '0;
    it.sw = '0;
    it.sx = '0;
    it.sy = '0;
    it.sz = '0;
    it.ax = x;
    it.ay = y;
    it.az = z;
    it.slot = '0;
    it.cj = '0;
    it.last = last;
    return it;
  endfunction

  function automatic pair_item_t rand_item();
    pair_item_t it;
    it.op = clpp_pkg::opcode_t'($urandom_range(0, 3));
    it.ci = IW'($urandom);
    it.sw = WW'($urandom);
    it.sx = clpp_pkg::coord_t'($urandom);
    it.sy = clpp_pkg::coord_t'($urandom);
    it.sz = clpp_pkg::coord_t'($urandom);
    it.ax = clpp_pkg::coord_t'($urandom);
    it.ay = clpp_pkg::coord_t'($urandom);
    it.az = clpp_pkg::coord_t'($urandom);
    it.slot = SLW'($urandom);
    it.cj = IW'($urandom);
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic clpp_pkg::coord_t near(longint c, int spread);
    return clpp_pkg::coord_t'(c + longint'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic send_item(pair_item_t it);
    logic [clpp_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[clpp_pkg::IN_CI_LSB +: IW] = it.ci;
    d[clpp_pkg::IN_SW_LSB +: WW] = it.sw;
    d[clpp_pkg::IN_SX_LSB +: CW] = it.sx;
    d[clpp_pkg::IN_SY_LSB +: CW] = it.sy;
    d[clpp_pkg::IN_SZ_LSB +: CW] = it.sz;
    d[clpp_pkg::IN_AX_LSB +: CW] = it.ax;
    d[clpp_pkg::IN_AY_LSB +: CW] = it.ay;
    d[clpp_pkg::IN_AZ_LSB +: CW] = it.az;
    d[clpp_pkg::IN_SLOT_LSB +: SLW] = it.slot;
    d[clpp_pkg::IN_CJ_LSB +: IW] = it.cj;
    s_axis_tdata <= d;
    s_axis_tuser <= it.op;
    s_axis_tlast <= it.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic wait_results_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [CTW-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.cutoff = 64'(v);
  endtask

  // one i-cluster: begin, shifted i atoms, j-clusters scattered around them, and usually an end
  task automatic send_pair_group();
    pair_item_t it;
    longint cx, cy, cz;
    longint s[3];
    int order[4];
    int n_clusters, n_atoms, pick, tmp, k, a;
    bit wild;
    cx = longint'($urandom_range(0, 1 << 28)) - (1 << 27);
    cy = longint'($urandom_range(0, 1 << 28)) - (1 << 27);
    cz = longint'($urandom_range(0, 1 << 28)) - (1 << 27);
    wild = ($urandom_range(0, 99) < 15);
    it = rand_item();
    it.op = clpp_pkg::OP_BEGIN;
    if (!wild) begin
      it.sx = near(0, 1 << 23);
      it.sy = near(0, 1 << 23);
      it.sz = near(0, 1 << 23);
    end
    s[0] = longint'(it.sx);
    s[1] = longint'(it.sy);
    s[2] = longint'(it.sz);
    send_item(it);
    order = '{0, 1, 2, 3};
    for (k = 3; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[pick];
      order[pick] = tmp;
    end
    for (k = 0; k < 4; k++) begin
      // now and then a slot keeps its stale coordinates
      if ($urandom_range(0, 99) < 8) continue;
      it = rand_item();
      it.op = clpp_pkg::OP_IATOM;
      it.slot = SLW'(order[k]);
      if (!wild) begin
        it.ax = near(cx - s[0], 1 << 20);
        it.ay = near(cy - s[1], 1 << 20);
        it.az = near(cz - s[2], 1 << 20);
      end
      send_item(it);
    end
    n_clusters = $urandom_range(0, 5);
    for (k = 0; k < n_clusters; k++) begin
      n_atoms = $urandom_range(1, 4);
      for (a = 0; a < n_atoms; a++) begin
        it = rand_item();
        it.op = clpp_pkg::OP_JATOM;
        it.last = (a == n_atoms - 1) && ($urandom_range(0, 99) >= 4);
        if ($urandom_range(0, 99) >= 10) begin
          it.ax = near(cx, 1 << 22);
          it.ay = near(cy, 1 << 22);
          it.az = near(cz, 1 << 22);
        end
        send_item(it);
      end
    end
    if ($urandom_range(0, 99) < 92) begin
      it = rand_item();
      it.op = clpp_pkg::OP_END;
      send_item(it);
    end
  endtask

  initial begin
    pair_item_t it;
    int idle_plan[4];
    int stall_plan[4];
    int ph, phase_end;
    bit paused;
    longint unsigned cut;
    idle_plan = '{0, 54, 0, 36};
    stall_plan = '{0, 0, 54, 36};
    paused = 0;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-scale cutoff: everything short of a saturated sum is kept
    write_cutoff(CTW'(RSQ_MAX));
    send_item(mk(clpp_pkg::OP_JATOM, 0, 0, 0, 1'b1));
    send_item(mk(clpp_pkg::OP_JATOM, COORD_MIN, 0, 0, 1'b0));
    it = mk(clpp_pkg::OP_JATOM, COORD_MIN, 0, 0, 1'b1);
    it.cj = '1;
    send_item(it);
    send_item(mk(clpp_pkg::OP_END, 0, 0, 0, 1'b0));
    send_item(mk(clpp_pkg::OP_END, 0, 0, 0, 1'b0));
    it = mk(clpp_pkg::OP_BEGIN, 0, 0, 0, 1'b0);
    it.ci = '1;
    it.sw = '1;
    it.sx = COORD_MAX;
    it.sy = COORD_MIN;
    it.sz = 1;
    send_item(it);
    send_item(mk(clpp_pkg::OP_IATOM, COORD_MAX, COORD_MIN, -1, 1'b0));
    it = mk(clpp_pkg::OP_IATOM, COORD_MIN, COORD_MAX, 0, 1'b0);
    it.slot = SLW'(1);
    send_item(it);
    it = mk(clpp_pkg::OP_IATOM, 1, 2, 3, 1'b0);
    it.slot = SLW'(3);
    send_item(it);
    it = mk(clpp_pkg::OP_JATOM, 0, 0, 0, 1'b1);
    it.cj = 24'haaaaaa;
    send_item(it);
    send_item(mk(clpp_pkg::OP_JATOM, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
    send_item(mk(clpp_pkg::OP_END, 0, 0, 0, 1'b0));
    wait_results_drained();

    // zero cutoff: nothing kept, entry suppressed
    write_cutoff('0);
    it = mk(clpp_pkg::OP_BEGIN, 0, 0, 0, 1'b0);
    it.ci = 24'h555555;
    it.sw = 16'h5555;
    send_item(it);
    send_item(mk(clpp_pkg::OP_JATOM, 0, 0, 0, 1'b1));
    send_item(mk(clpp_pkg::OP_END, 0, 0, 0, 1'b0));
    wait_results_drained();

    // smallest nonzero cutoff: only exact overlap counts, partial cluster dropped by begin
    write_cutoff(CTW'(1));
    send_item(mk(clpp_pkg::OP_BEGIN, 0, 0, 0, 1'b0));
    send_item(mk(clpp_pkg::OP_IATOM, 7, 7, 7, 1'b0));
    send_item(mk(clpp_pkg::OP_JATOM, 7, 7, 7, 1'b0));
    send_item(mk(clpp_pkg::OP_BEGIN, 0, 0, 0, 1'b0));
    send_item(mk(clpp_pkg::OP_JATOM, 100, 100, 100, 1'b1));
    send_item(mk(clpp_pkg::OP_JATOM, 7, 7, 7, 1'b1));
    send_item(mk(clpp_pkg::OP_JATOM, 8, 7, 7, 1'b1));
    send_item(mk(clpp_pkg::OP_END, 0, 0, 0, 1'b0));

    for (ph = 0; ph < 4; ph++) begin
      wait_results_drained();
      send_idle_pct = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      case (ph)
        0: cut = 64'd1 << 42;
        1: cut = (64'd1 << 41) + 64'($urandom);
        2: cut = 64'd1 << 43;
        default: cut = (64'($urandom_range(256, 4096)) << 32) | 64'($urandom);
      endcase
      write_cutoff(CTW'(cut));
      phase_end = sb.items + PHASE_BEATS;
      while (sb.items < phase_end) begin
        if (ph == 1 && !paused && sb.items >= phase_end - PHASE_BEATS / 2) begin
          wait_results_drained();
          paused = 1;
        end
        if ($urandom_range(0, 99) < 85) begin
          send_pair_group();
        end else begin
          repeat ($urandom_range(1, 3)) send_item(rand_item());
        end
      end
    end
    wait_results_drained();

    $display("%0d input beats, %0d j-cluster verdicts (%0d kept), %0d i-entries emitted",
             sb.items, sb.verdicts, sb.kept_verdicts, sb.entries);
    $display("cutoffs zero, one, full scale and near 1 nm; four sender/receiver idling mixes");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/clpp_pkg.sv
hw/rtl/clpp_rsq_check.sv
hw/rtl/cluster_pair_list_prune_core.sv
hw/rtl/clpp_port_checker.sv
tb/sv/tb.sv
